// ===== rtl/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// No dependencies; imported by every module of the block but bpa_bitmap_ram.
package bpa_pkg;

    // Default sizes handed to the top level parameters
    localparam int TOTAL_PAGES_DEF = 65536;
    localparam int WORD_BITS_DEF   = 32;
    localparam int MAX_WPG_DEF     = 128;

    // Fixed field widths
    localparam int PAGE_W      = 16;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int WPG_W       = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MARK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INIT  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WPG = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RSV = 8'd1;

    // Configuration seen by the engine (group size already clamped)
    typedef struct packed {
        logic [WPG_W-1:0]      wpg;
        logic [CFG_DATA_W-1:0] rsv;
    } t_cfg;

    // One result
    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic                in_use;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// ===== rtl/bpa_bitmap_ram.sv =====
// Free-page bitmap storage: one write port, one read port, registered read.
// Depends on nothing beyond its parameters.
module bpa_bitmap_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpa_grp_rem.sv =====
// Serial remainder unit: word index modulo words-per-group, one bit a cycle.
// Uses bpa_pkg for the group-size width.
module bpa_grp_rem import bpa_pkg::*; #(
    parameter int DW = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_dividend,
    input  logic [WPG_W-1:0] i_divisor,
    output logic             o_done,
    output logic [WPG_W-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_dvd;
    logic [WPG_W-1:0] r_rem;

    logic [WPG_W:0]   trial;
    logic             ge;
    logic [WPG_W-1:0] n_rem;

    // Restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[DW-1]};
        ge    = trial >= {1'b0, i_divisor};
        n_rem = ge ? WPG_W'(trial - {1'b0, i_divisor}) : trial[WPG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Pulse once after the last step
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_dvd  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/bpa_engine.sv =====
// Request sequencer: read-modify-write of the bitmap RAM, allocation scan,
// clearing pass and hint. Uses bpa_pkg, bpa_bitmap_ram and bpa_grp_rem.
module bpa_engine import bpa_pkg::*; #(
    parameter int TOTAL_PAGES = TOTAL_PAGES_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [PAGE_W-1:0] i_page,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    // Derived sizes; WORD_BITS is a power of two
    localparam int EFF_PAGES = (TOTAL_PAGES < 65536) ? TOTAL_PAGES : 65536;
    localparam int NWORDS    = (EFF_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = $clog2(NWORDS);
    localparam int WB_LOG    = $clog2(WORD_BITS);
    localparam int LAST_BITS = EFF_PAGES - (NWORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] LAST_MASK = ONES >> (WORD_BITS - LAST_BITS);
    localparam logic [AW-1:0]        LAST_WORD = AW'(NWORDS - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_DIV, S_ARD, S_AEV, S_MEV, S_RESP
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_addr;
    logic [WPG_W-1:0]    r_gw;
    logic [PAGE_W-1:0]   r_hint;
    logic [PAGE_W-1:0]   r_page;
    logic [MODE_W-1:0]   r_mode;
    logic                r_init;
    t_result             r_res;

    logic                acc;
    logic                in_range;
    logic [STATUS_W-1:0] in_status;
    logic [AW-1:0]       in_word;
    logic [AW-1:0]       hint_word;
    logic                div_start;
    logic                div_done;
    logic [WPG_W-1:0]    div_rem;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [WORD_BITS-1:0] rd_data;

    logic                last_word;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] low;
    logic                found;
    logic [WB_LOG-1:0]   idx;
    logic                tail_word;
    logic                is_tail;
    logic [PAGE_W-1:0]   alloc_page;
    logic [WB_LOG-1:0]   bsel;
    logic [WORD_BITS-1:0] bmask;
    logic [PAGE_W-1:0]   hint_free;
    logic [WORD_BITS-1:0] rsv_w;

    assign acc       = i_req_valid && (r_state == S_IDLE);
    assign in_range  = 32'(i_page) < EFF_PAGES;
    assign in_word   = AW'(i_page >> WB_LOG);
    assign hint_word = AW'(r_hint >> WB_LOG);
    assign div_start = acc && (i_mode == MODE_ALLOC);
    assign last_word = (r_addr == LAST_WORD);
    assign rsv_w     = WORD_BITS'(i_cfg.rsv);

    // Status known at accept: page out of range for free, mark and query
    assign in_status = ((i_mode == MODE_FREE || i_mode == MODE_MARK || i_mode == MODE_QUERY)
                        && !in_range) ? ST_RANGE : ST_OK;

    // Scan: lowest free page of the current word, and the group tail check
    always_comb begin
        avail = rd_data & (last_word ? LAST_MASK : ONES);
        low   = avail & (~avail + 1'b1);
        found = |avail;
        idx   = '0;
        for (int k = 0; k < WB_LOG; k++) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                if (((j >> k) & 1) != 0) begin
                    idx[k] = idx[k] | low[j];
                end
            end
        end
        tail_word  = (r_gw == (i_cfg.wpg - 1'b1));
        is_tail    = tail_word && low[WORD_BITS-1];
        alloc_page = PAGE_W'({r_addr, idx});
    end

    // Single-page access
    assign bsel      = r_page[WB_LOG-1:0];
    assign bmask     = WORD_BITS'(1) << bsel;
    assign hint_free = (r_page == '0) ? '0 : r_page - 1'b1;

    // Read address: incoming page word while idle, next word while scanning
    always_comb begin
        unique case (r_state)
            S_IDLE:  mem_raddr = in_word;
            S_AEV:   mem_raddr = r_addr + 1'b1;
            default: mem_raddr = r_addr;
        endcase
    end

    // Write port
    always_comb begin
        mem_waddr = r_addr;
        mem_we    = 1'b0;
        mem_wdata = rd_data;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = (r_addr == '0) ? (ONES & ~rsv_w) : ONES;
            end
            S_AEV: begin
                mem_we    = found;
                mem_wdata = rd_data & ~low;
            end
            S_MEV: begin
                mem_waddr = AW'(r_page >> WB_LOG);
                mem_we    = (r_mode == MODE_FREE) || (r_mode == MODE_MARK);
                mem_wdata = (r_mode == MODE_FREE) ? (rd_data | bmask) : (rd_data & ~bmask);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    bpa_bitmap_ram #(
        .DEPTH (NWORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    bpa_grp_rem #(
        .DW (AW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (hint_word),
        .i_divisor  (i_cfg.wpg),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_hint  <= '0;
            r_init  <= 1'b0;
            r_gw    <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (last_word) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_mode <= i_mode;
                        r_page <= i_page;
                        r_res  <= '{page: i_page, in_use: 1'b0, status: in_status};
                        unique case (i_mode)
                            MODE_ALLOC: begin
                                r_state <= S_DIV;
                            end
                            MODE_FREE, MODE_MARK, MODE_QUERY: begin
                                if (in_range) begin
                                    r_state <= S_MEV;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                            MODE_INIT: begin
                                r_hint  <= '0;
                                r_addr  <= '0;
                                r_init  <= 1'b1;
                                r_state <= S_CLR;
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    // Start of the hint's group
                    if (div_done) begin
                        r_addr  <= AW'(PAGE_W'(hint_word) - PAGE_W'(div_rem));
                        r_gw    <= '0;
                        r_state <= S_ARD;
                    end
                end
                S_ARD: begin
                    r_state <= S_AEV;
                end
                S_AEV: begin
                    if (found && !is_tail) begin
                        r_hint  <= alloc_page;
                        r_res   <= '{page: alloc_page, in_use: 1'b1, status: ST_OK};
                        r_state <= S_RESP;
                    end else if (last_word) begin
                        r_res   <= '{page: '0, in_use: 1'b0, status: ST_FULL};
                        r_state <= S_RESP;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                        r_gw   <= tail_word ? '0 : r_gw + 1'b1;
                    end
                end
                S_MEV: begin
                    priority if (r_mode == MODE_FREE) begin
                        r_res.in_use <= 1'b0;
                        if (hint_free < r_hint) begin
                            r_hint <= hint_free;
                        end
                    end else if (r_mode == MODE_MARK) begin
                        r_res.in_use <= 1'b1;
                    end else begin
                        r_res.in_use <= ~rd_data[bsel];
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

    // A successful allocation leaves the hint on the page handed out
    a_alloc_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_mode == MODE_ALLOC && r_res.status == ST_OK)
        |-> (r_hint == r_res.page))
        else $error("hint does not follow allocated page");

    // Freeing a page never raises the hint
    a_free_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEV && r_mode == MODE_FREE) |=> (r_hint <= $past(r_hint)))
        else $error("free raised the hint");

    // Group remainder stays below the group size
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (div_rem < i_cfg.wpg))
        else $error("group remainder out of range");

    // A page reported in use comes with a good status
    a_use_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_res.in_use) |-> (r_res.status == ST_OK))
        else $error("in_use set with error status");

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap page allocator: one bit per page in a block RAM (set = free) plus an
// allocation hint. Requests are taken one at a time. Free, mark and query read
// the page's word, and free and mark write it back. Allocate first runs a
// serial remainder unit to find the hint's group (one word-address bit per
// cycle, 11 bits at the defaults), then scans the bitmap one RAM word per
// cycle from that group. Initialize rewrites every word, one per cycle (2048
// words at the defaults). After reset the same clearing pass runs over every
// word with the input side not ready; configuration writes are accepted
// throughout. A finished result sits in an output register, so the next
// request can be accepted while it waits.
// Depends on bpa_pkg and bpa_engine.
module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int TOTAL_PAGES         = TOTAL_PAGES_DEF,
    parameter int WORD_BITS           = WORD_BITS_DEF,
    parameter int MAX_WORDS_PER_GROUP = MAX_WPG_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [15:0] page_number
    input  logic [MODE_W-1:0]      i_s_axis_tuser,  // [2:0] mode
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // [15:0] result_page, [16] in_use
    output logic [STATUS_W-1:0]    o_m_axis_tuser,  // [1:0] status
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [WPG_W-1:0]      r_wpg;
    logic [CFG_DATA_W-1:0] r_rsv;
    logic [WPG_W-1:0]      wpg_eff;
    t_cfg                  cfg;

    logic                  res_valid;
    logic                  res_ready;
    t_result               res;
    logic                  r_out_valid;
    t_result               r_out;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpg <= WPG_W'(32);
            r_rsv <= CFG_DATA_W'(15);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WPG) begin
                r_wpg <= i_cfg_data[WPG_W-1:0];
            end else if (i_cfg_index == REG_RSV) begin
                r_rsv <= i_cfg_data;
            end
        end
    end

    // Group size clamped to 1..MAX_WORDS_PER_GROUP
    always_comb begin
        priority if (r_wpg == '0) begin
            wpg_eff = WPG_W'(1);
        end else if (32'(r_wpg) > MAX_WORDS_PER_GROUP) begin
            wpg_eff = WPG_W'(MAX_WORDS_PER_GROUP);
        end else begin
            wpg_eff = r_wpg;
        end
        cfg = '{wpg: wpg_eff, rsv: r_rsv};
    end

    bpa_engine #(
        .TOTAL_PAGES (TOTAL_PAGES),
        .WORD_BITS   (WORD_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_page      (i_s_axis_tdata[PAGE_W-1:0]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
            r_out       <= res;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out.in_use, r_out.page});
    assign o_m_axis_tuser  = r_out.status;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bitmap_page_allocator: drives request and config streams,
// keeps a shadow copy of the free-page bitmap and hint, and checks every result.
// Depends on bpa_pkg and the RTL of bitmap_page_allocator.

// Shadow of the allocator state; predicts each result and holds it until it arrives
class bitmap_shadow;
    localparam int WBITS   = bpa_pkg::WORD_BITS_DEF;
    localparam int NPAGES  = (bpa_pkg::TOTAL_PAGES_DEF < 65536) ?
                             bpa_pkg::TOTAL_PAGES_DEF : 65536;
    localparam int NWORDS  = (NPAGES + WBITS - 1) / WBITS;

    bit [WBITS-1:0]   free_map [NWORDS];
    bit [15:0]        hint;
    bit [7:0]         wpg;
    bit [31:0]        rsv;
    bpa_pkg::t_result pending_results [$];
    int               errors;

    function new();
        wpg  = 8'd32;
        rsv  = 32'd15;
        hint = '0;
        errors = 0;
        reload_map();
    endfunction

    function void reload_map();
        foreach (free_map[i]) free_map[i] = '1;
        free_map[0] &= ~rsv[WBITS-1:0];
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
        if (idx == bpa_pkg::REG_WPG) wpg = data[7:0];
        else if (idx == bpa_pkg::REG_RSV) rsv = data;
    endfunction

    // group size in pages, with the words-per-group clamp applied
    function int group_pages();
        int w;
        w = wpg;
        if (w == 0) w = 1;
        if (w > bpa_pkg::MAX_WPG_DEF) w = bpa_pkg::MAX_WPG_DEF;
        return w * WBITS;
    endfunction

    // lowest free page from the hint's group; group tail pages are consumed on the way
    function bit take_free_page(output bit [15:0] pg);
        int gs;
        int w;
        int p;
        gs = group_pages();
        pg = '0;
        for (w = ((int'(hint) / gs) * gs) / WBITS; w < NWORDS; w++) begin
            if (free_map[w] == '0) continue;
            for (int b = 0; b < WBITS; b++) begin
                p = w * WBITS + b;
                if (p >= NPAGES) break;
                if (!free_map[w][b]) continue;
                free_map[w][b] = 1'b0;
                if (p % gs == gs - 1) continue;
                hint = p[15:0];
                pg   = p[15:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void note_request(logic [2:0] mode, logic [15:0] pg);
        bpa_pkg::t_result r;
        bit [15:0]        got;
        bit [15:0]        lowered;
        int               wi;
        int               bi;
        r.page   = pg;
        r.in_use = 1'b0;
        r.status = bpa_pkg::ST_OK;
        wi = int'(pg) / WBITS;
        bi = int'(pg) % WBITS;
        case (mode)
            bpa_pkg::MODE_ALLOC: begin
                if (take_free_page(got)) begin
                    r.page   = got;
                    r.in_use = 1'b1;
                end else begin
                    r.page   = '0;
                    r.status = bpa_pkg::ST_FULL;
                end
            end
            bpa_pkg::MODE_FREE, bpa_pkg::MODE_MARK, bpa_pkg::MODE_QUERY: begin
                if (int'(pg) >= NPAGES) begin
                    r.status = bpa_pkg::ST_RANGE;
                end else begin
                    if (mode == bpa_pkg::MODE_FREE) begin
                        free_map[wi][bi] = 1'b1;
                        lowered = (pg == 0) ? 16'd0 : pg - 16'd1;
                        if (lowered < hint) hint = lowered;
                    end else if (mode == bpa_pkg::MODE_MARK) begin
                        free_map[wi][bi] = 1'b0;
                    end
                    r.in_use = ~free_map[wi][bi];
                end
            end
            bpa_pkg::MODE_INIT: begin
                reload_map();
                hint = '0;
            end
            default: ;
        endcase
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [15:0] pg, logic used, logic [1:0] st);
        bpa_pkg::t_result e;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result page=%h in_use=%b status=%0d",
                     $time, pg, used, st);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (pg !== e.page) begin
            $display("%0t: result_page expected %h got %h", $time, e.page, pg);
            errors++;
        end
        if (used !== e.in_use) begin
            $display("%0t: in_use expected %b got %b (page %h)", $time, e.in_use, used, e.page);
            errors++;
        end
        if (st !== e.status) begin
            $display("%0t: status expected %0d got %0d (page %h)", $time, e.status, st, e.page);
            errors++;
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module testbench;
    import bpa_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [MODE_W-1:0]      i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]    o_m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    bitmap_shadow shadow = new();
    bit           calm   = 1'b0;   // no idling on either side while set

    bitmap_page_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side backpressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
    end

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                shadow.write_reg(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                shadow.note_request(i_s_axis_tuser, i_s_axis_tdata[15:0]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                shadow.check_result(o_m_axis_tdata[15:0], o_m_axis_tdata[16], o_m_axis_tuser);
        end
    end

    // one request; returns at the edge it is accepted, tvalid left high
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [15:0] pg);
        while (!calm && $urandom_range(99) < 31) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pg;
        i_s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // stop requesting and wait until every predicted result has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    // idle the block, load both registers, then re-initialize the bitmap
    task automatic new_phase(input logic [7:0] wpg, input logic [31:0] rsv);
        drain();
        cfg_write(REG_WPG, {24'd0, wpg});
        cfg_write(REG_RSV, rsv);
        i_cfg_valid <= 1'b0;
        send_request(MODE_INIT, 16'($urandom));
    endtask

    // mostly low pages, where allocations land; sometimes anywhere
    function automatic logic [15:0] pick_page(input bit wide);
        if (wide || $urandom_range(99) < 30) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 767));
    endfunction

    // random mix; crowded selects the near-full mix of frees and allocations
    task automatic run_random(input int count, input bit crowded);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (crowded) begin
                if (r < 45) send_request(MODE_FREE, pick_page(1'b1));
                else if (r < 90) send_request(MODE_ALLOC, 16'($urandom));
                else send_request(MODE_QUERY, pick_page(1'b1));
            end else begin
                if (r < 38) send_request(MODE_ALLOC, 16'($urandom));
                else if (r < 62) send_request(MODE_FREE, pick_page(1'b0));
                else if (r < 74) send_request(MODE_MARK, pick_page(1'b0));
                else if (r < 94) send_request(MODE_QUERY, pick_page(1'b0));
                else if (r < 95) send_request(MODE_INIT, 16'($urandom));
                else send_request(3'($urandom_range(5, 7)), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: reserved pages, extremes, hint at zero, unknown modes
        send_request(MODE_QUERY, 16'd0);
        send_request(MODE_QUERY, 16'd3);
        send_request(MODE_QUERY, 16'd4);
        send_request(MODE_QUERY, 16'hFFFF);
        send_request(MODE_ALLOC, 16'hFFFF);
        send_request(MODE_ALLOC, 16'd0);
        send_request(MODE_MARK, 16'hFFFF);
        send_request(MODE_QUERY, 16'hFFFF);
        send_request(MODE_FREE, 16'hFFFF);
        send_request(MODE_FREE, 16'd0);
        send_request(MODE_ALLOC, 16'd0);
        send_request(MODE_FREE, 16'd0);
        send_request(3'd5, 16'hFFFF);
        send_request(3'd6, 16'd0);
        send_request(3'd7, 16'hAAAA);
        send_request(MODE_INIT, 16'h5555);
        send_request(MODE_ALLOC, 16'h0);
        send_request(MODE_QUERY, 16'd0);
        run_random(200, 1'b0);

        // one-word groups: the scan runs into group tail pages
        new_phase(8'd1, 32'h7FFF_FFFF);
        send_request(MODE_ALLOC, 16'd0);
        send_request(MODE_QUERY, 16'd31);
        send_request(MODE_ALLOC, 16'd0);
        send_request(MODE_FREE, 16'd31);
        send_request(MODE_ALLOC, 16'd0);
        send_request(MODE_QUERY, 16'd31);
        run_random(200, 1'b0);

        // group size zero acts as one word, no reserved pages
        new_phase(8'd0, 32'h0000_0000);
        run_random(200, 1'b0);

        // largest groups, whole first word reserved
        new_phase(8'd128, 32'hFFFF_FFFF);
        run_random(200, 1'b0);

        // oversized group setting clamps
        new_phase(8'd255, $urandom);
        run_random(200, 1'b0);

        new_phase(8'($urandom_range(1, 128)), $urandom);
        run_random(200, 1'b0);

        // crowd the low words with no idling, so allocations scan past used words
        new_phase(8'd200, 32'hFFFF_FFFF);
        calm = 1'b1;
        for (int p = 32; p < 64; p++) send_request(MODE_MARK, 16'(p));
        send_request(MODE_ALLOC, 16'd0);
        send_request(MODE_FREE, 16'hFFFF);      // last group's tail page
        send_request(MODE_ALLOC, 16'd0);
        send_request(MODE_QUERY, 16'hFFFF);
        send_request(MODE_FREE, 16'd40000);
        send_request(MODE_ALLOC, 16'd0);
        run_random(100, 1'b1);
        calm = 1'b0;

        drain();
        repeat (32) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial begin
        #160_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bpa_pkg.sv
rtl/bpa_bitmap_ram.sv
rtl/bpa_grp_rem.sv
rtl/bpa_engine.sv
rtl/bitmap_page_allocator.sv
tb/sv/testbench.sv
